@@ hw/rtl/dpv_pkg.sv @@
package dpv_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_PATH_NOT_FOUND = 2'd1,
    ST_NO_MORE_FILES  = 2'd2,
    ST_FILE_NOT_FOUND = 2'd3
  } status_t;

  // Segment check phase, one-hot.
  typedef enum logic [1:0] {
    PHASE_NAME = 2'b01,
    PHASE_EXT  = 2'b10
  } phase_t;

  // One classified path byte as it travels from the front to the back.
  typedef struct packed {
    logic is_nul;
    logic is_bslash;
    logic is_dot;
    logic dir_ok;
    logic name_ok;
  } item_t;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // First table entry checked for each class.
  localparam logic [3:0] EXCL_PLAIN    = 4'd0;
  localparam logic [3:0] EXCL_WILDCARD = 4'd2;
  localparam logic [3:0] EXCL_DIR      = 4'd5;

  localparam logic [7:0] EXCL_TAB [16] = '{
    8'h2A, 8'h3F, 8'h2E, 8'h2F, 8'h5C, 8'h22, 8'h5B, 8'h5D,
    8'h3A, 8'h7C, 8'h3C, 8'h3E, 8'h2B, 8'h3D, 8'h3B, 8'h2C
  };

  // True when the byte is printable and matches no table entry from first on.
  function automatic logic class_ok(input logic [7:0] c, input logic [3:0] first);
    logic ok;
    ok = (c >= CH_SPACE);
    for (int i = 0; i < 16; i++) begin
      if ((4'(i) >= first) && (EXCL_TAB[i] == c)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ hw/rtl/dpv_front.sv @@
module dpv_front (
  input  logic [7:0]     char_in,
  input  logic           allow_wildcards,
  output dpv_pkg::item_t item
);
  import dpv_pkg::*;

  // Wildcard mode drops * and ? from the name exclusions.
  always_comb begin
    item.is_nul    = (char_in == 8'h00);
    item.is_bslash = (char_in == CH_BSLASH);
    item.is_dot    = (char_in == CH_DOT);
    item.dir_ok    = class_ok(char_in, EXCL_DIR);
    item.name_ok   = class_ok(char_in, allow_wildcards ? EXCL_WILDCARD : EXCL_PLAIN);
  end

endmodule

@@ hw/rtl/dpv_queue.sv @@
module dpv_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpv_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output dpv_pkg::item_t head_item,
  output logic           empty
);
  import dpv_pkg::*;

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign empty     = (count == '0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/dpv_back.sv @@
module dpv_back #(
  parameter int MAX_PATH_LEN = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             allow_wildcards,
  input  dpv_pkg::item_t   item,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output dpv_pkg::status_t out_status,
  output logic [7:0]       out_dir_length
);
  import dpv_pkg::*;

  localparam int PW = $clog2(MAX_PATH_LEN + 1);
  localparam logic [PW-1:0] PMAX = PW'(MAX_PATH_LEN);

  logic          dir_scan_active, dir_scan_active_next;
  logic [PW-1:0] position, position_next;
  logic [PW-1:0] segment_start, segment_start_next;
  phase_t        segment_phase, segment_phase_next;
  logic          name_seen, name_seen_next;
  status_t       segment_verdict, segment_verdict_next;
  logic          had_backslash, had_backslash_next;
  logic          emit;
  status_t       emit_status;
  logic [7:0]    emit_len;

  // A NUL may only leave the queue when the output register is free.
  assign pop  = !empty && (!item.is_nul || !out_valid || out_ready);
  assign emit = pop && item.is_nul;

  always_comb begin
    logic [PW-1:0] pos_inc;
    logic          skip;
    pos_inc = (position >= PMAX) ? PMAX : position + 1'b1;
    skip    = 1'b0;

    dir_scan_active_next = dir_scan_active;
    position_next        = position;
    segment_start_next   = segment_start;
    segment_phase_next   = segment_phase;
    name_seen_next       = name_seen;
    segment_verdict_next = segment_verdict;
    had_backslash_next   = had_backslash;
    emit_status          = ST_OK;
    emit_len             = 8'h00;

    if (segment_verdict != ST_OK) begin
      emit_status = segment_verdict;
    end else if (segment_phase == PHASE_NAME && !name_seen) begin
      if (allow_wildcards && (!had_backslash || segment_start == PW'(3))) begin
        emit_status = ST_NO_MORE_FILES;
      end else begin
        emit_status = ST_PATH_NOT_FOUND;
      end
    end else begin
      emit_len = 8'(segment_start);
    end

    if (pop) begin
      if (item.is_nul) begin
        dir_scan_active_next = 1'b1;
        position_next        = '0;
        segment_start_next   = '0;
        segment_phase_next   = PHASE_NAME;
        name_seen_next       = 1'b0;
        segment_verdict_next = ST_OK;
        had_backslash_next   = 1'b0;
      end else begin
        position_next = pos_inc;
        if (dir_scan_active && position >= PW'(2)) begin
          if (!item.dir_ok) begin
            dir_scan_active_next = 1'b0;
          end else if (item.is_bslash) begin
            segment_start_next   = pos_inc;
            segment_phase_next   = PHASE_NAME;
            name_seen_next       = 1'b0;
            segment_verdict_next = ST_OK;
            had_backslash_next   = 1'b1;
            skip                 = 1'b1;
          end
        end
        if (!skip && segment_verdict == ST_OK) begin
          if (segment_phase == PHASE_NAME) begin
            if (item.name_ok) begin
              name_seen_next = 1'b1;
            end else if (!name_seen) begin
              segment_verdict_next = ST_PATH_NOT_FOUND;
            end else if (item.is_dot) begin
              segment_phase_next = PHASE_EXT;
            end else begin
              segment_verdict_next = ST_FILE_NOT_FOUND;
            end
          end else if (!item.name_ok) begin
            segment_verdict_next = ST_FILE_NOT_FOUND;
          end
        end
      end
    end
  end

  // The path state returns to its start values after every NUL.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_scan_active <= 1'b1;
      position        <= '0;
      segment_start   <= '0;
      segment_phase   <= PHASE_NAME;
      name_seen       <= 1'b0;
      segment_verdict <= ST_OK;
      had_backslash   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      dir_scan_active <= dir_scan_active_next;
      position        <= position_next;
      segment_start   <= segment_start_next;
      segment_phase   <= segment_phase_next;
      name_seen       <= name_seen_next;
      segment_verdict <= segment_verdict_next;
      had_backslash   <= had_backslash_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status     <= emit_status;
      out_dir_length <= emit_len;
    end
  end

endmodule

@@ hw/rtl/dos_path_name_validator.sv @@
// DOS path name validator.
//
// A full path streams in on the s_ channel, one byte per transaction, and a
// NUL byte ends it. For every NUL the block sends one transaction on the m_
// channel carrying a status (ok, path not found, no more files, file not
// found) and the length of the directory prefix, which is zero unless the
// status is ok. Non-NUL bytes produce no output.
//
// The cfg_we/cfg_wdata port writes allow_wildcards, which lets * and ? pass
// in file names; it must only be written while the block is idle.
//
// Throughput is one byte per cycle while the queue has room. A NUL is
// first written into the classification queue, and its result is
// registered in the output register when the NUL leaves the queue. A
// four-entry queue separates the byte classifier from the state update, so
// the input keeps flowing while a result waits; once the receiver stalls and
// the queue fills behind a second NUL, s_tready drops. Reset clears the
// queue, the path state and m_tvalid and sets allow_wildcards to zero.
module dos_path_name_validator #(
  parameter int MAX_PATH_LEN = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] status, [9:2] dir_length, rest zero
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import dpv_pkg::*;

  logic    allow_wildcards;
  item_t   front_item;
  item_t   head_item;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    push;
  status_t status;
  logic [7:0] dir_length;

  // Configuration register, written directly with no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_wildcards <= 1'b0;
    end else if (cfg_we) begin
      allow_wildcards <= cfg_wdata;
    end
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // Front: classify each byte against the directory and name character sets.
  dpv_front u_front (
    .char_in         (s_tdata),
    .allow_wildcards (allow_wildcards),
    .item            (front_item)
  );

  dpv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  // Back: walk the path state and produce the result on each NUL. The
  // no-more-files status only exists in wildcard mode, so the back part
  // needs the mode as well.
  dpv_back #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .allow_wildcards (allow_wildcards),
    .item            (head_item),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_status      (status),
    .out_dir_length  (dir_length)
  );

  assign m_tdata = {6'b000000, dir_length, status};

endmodule

@@ dv/dos_path_name_validator_tb.sv @@
module dos_path_name_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpv_pkg::*;

  // The block's default saturation point for position counters.
  localparam int PATH_SAT = 255;
  // Cycles to let the classification queue and output register settle
  // after the last expected result.
  localparam int SETTLE_CYCLES = 8;
  // Far above the slowest legal run of under a thousand bytes.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 150;

  // One expected verdict for a NUL-terminated path.
  typedef struct {
    status_t    status;
    logic [7:0] dir_len;
  } path_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] char_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [1:0] status, [9:2] dir_length, rest zero
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;

  dos_path_name_validator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predicted verdicts, oldest first, waiting for their output transaction.
  path_verdict_t path_verdicts_q[$];

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int paths_sent = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  // Percentage of cycles in which each side holds off.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Shadow of the path checker. The names mirror the block's behavior:
  // whether the directory scan still runs, the byte position, where the
  // current segment began, and the per-segment error latch.
  logic    wildcards_on;
  logic    scan_live;
  int      byte_pos;
  int      seg_base;
  phase_t  seg_phase;
  logic    seg_has_name;
  status_t seg_error;
  logic    saw_bslash;

  // Directory characters: printable and none of  " [ ] : | < > + = ; ,
  function automatic logic is_dir_byte(input logic [7:0] c);
    case (c)
      8'h22, 8'h5B, 8'h5D, 8'h3A, 8'h7C, 8'h3C,
      8'h3E, 8'h2B, 8'h3D, 8'h3B, 8'h2C: return 1'b0;
      default: return c >= CH_SPACE;
    endcase
  endfunction

  // Wildcard-class name characters additionally exclude  . / backslash
  function automatic logic is_wild_byte(input logic [7:0] c);
    if (c == CH_DOT || c == 8'h2F || c == CH_BSLASH) begin
      return 1'b0;
    end
    return is_dir_byte(c);
  endfunction

  // Plain name characters additionally exclude  * ?
  function automatic logic is_plain_byte(input logic [7:0] c);
    if (c == 8'h2A || c == 8'h3F) begin
      return 1'b0;
    end
    return is_wild_byte(c);
  endfunction

  function automatic int sat_next(input int v);
    return (v >= PATH_SAT) ? PATH_SAT : v + 1;
  endfunction

  task automatic clear_path_state();
    scan_live    = 1'b1;
    byte_pos     = 0;
    seg_base     = 0;
    seg_phase    = PHASE_NAME;
    seg_has_name = 1'b0;
    seg_error    = ST_OK;
    saw_bslash   = 1'b0;
  endtask

  // Advances the shadow state by one accepted byte. A NUL closes the path
  // and yields the verdict; every other byte only updates the state.
  task automatic advance_path(input logic [7:0] c, output logic done,
                              output path_verdict_t verdict);
    int   p;
    logic name_ok;
    done = 1'b0;
    verdict.status  = ST_OK;
    verdict.dir_len = 8'h00;
    if (c == 8'h00) begin
      done = 1'b1;
      if (seg_error != ST_OK) begin
        verdict.status = seg_error;
      end else if (seg_phase == PHASE_NAME && !seg_has_name) begin
        // An empty final name means a bare directory: with wildcards on,
        // the drive root or a path without any backslash reads as a search
        // that found nothing.
        if (wildcards_on && (seg_base == 3 || !saw_bslash)) begin
          verdict.status = ST_NO_MORE_FILES;
        end else begin
          verdict.status = ST_PATH_NOT_FOUND;
        end
      end else begin
        verdict.dir_len = seg_base[7:0];
      end
      clear_path_state();
      return;
    end

    p = byte_pos;
    byte_pos = sat_next(p);

    // The scan skips drive letter and colon, and stops at the first byte
    // that cannot appear in a directory name.
    if (scan_live && p >= 2) begin
      if (!is_dir_byte(c)) begin
        scan_live = 1'b0;
      end else if (c == CH_BSLASH) begin
        seg_base     = sat_next(p);
        seg_phase    = PHASE_NAME;
        seg_has_name = 1'b0;
        seg_error    = ST_OK;
        saw_bslash   = 1'b1;
        return;
      end
    end

    if (seg_error == ST_OK) begin
      name_ok = wildcards_on ? is_wild_byte(c) : is_plain_byte(c);
      if (seg_phase == PHASE_NAME) begin
        if (name_ok) begin
          seg_has_name = 1'b1;
        end else if (!seg_has_name) begin
          seg_error = ST_PATH_NOT_FOUND;
        end else if (c == CH_DOT) begin
          seg_phase = PHASE_EXT;
        end else begin
          seg_error = ST_FILE_NOT_FOUND;
        end
      end else if (!name_ok) begin
        seg_error = ST_FILE_NOT_FOUND;
      end
    end
  endtask

  // Offers one byte on the input channel, with random hold-off first, and
  // feeds it to the shadow state once the transaction completes. tvalid is
  // left high on return so that bytes can be sent back to back.
  task automatic send_char(input logic [7:0] c);
    logic          done;
    path_verdict_t verdict;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    bytes_sent++;
    advance_path(c, done, verdict);
    if (done) begin
      paths_sent++;
      path_verdicts_q.push_back(verdict);
    end
  endtask

  task automatic send_path(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i]);
    end
    send_char(8'h00);
  endtask

  // Stops offering bytes until every predicted verdict has come back, then
  // lets the pipeline settle, since trailing bytes produce no output.
  task automatic wait_for_verdicts();
    s_tvalid <= 1'b0;
    while (path_verdicts_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_wildcards(input logic on);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wildcards_on = on;
  endtask

  // Mostly name characters, with wildcards, odd printable bytes and the
  // occasional control or high byte mixed in.
  function automatic logic [7:0] random_name_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) begin
      return 8'h41 + 8'($urandom_range(25));
    end else if (r < 65) begin
      return 8'h30 + 8'($urandom_range(9));
    end else if (r < 75) begin
      return ($urandom_range(1) == 0) ? 8'h2A : 8'h3F;
    end else if (r < 92) begin
      return 8'($urandom_range(255, 32));
    end
    return 8'($urandom_range(255, 1));
  endfunction

  // Builds a drive-rooted path with random directory and file names. A
  // long run carries enough directories to push both counters past their
  // saturation point. A share of paths get one byte corrupted, and a few
  // are pure noise.
  task automatic send_random_path(input bit long_run);
    logic [7:0] path[$];
    int         n_dirs;
    if ($urandom_range(99) < 90) begin
      path.push_back(8'h41 + 8'($urandom_range(25)));
      path.push_back(8'h3A);
    end else begin
      path.push_back(random_name_char());
      path.push_back(random_name_char());
    end
    if (long_run || $urandom_range(99) < 85) begin
      path.push_back(CH_BSLASH);
    end
    n_dirs = long_run ? 45 : $urandom_range(3);
    repeat (n_dirs) begin
      repeat (long_run ? $urandom_range(8, 5) : $urandom_range(8)) begin
        path.push_back(random_name_char());
      end
      path.push_back(CH_BSLASH);
    end
    repeat ($urandom_range(8)) path.push_back(random_name_char());
    if ($urandom_range(2) != 0) begin
      path.push_back(CH_DOT);
      repeat ($urandom_range(3)) path.push_back(random_name_char());
    end
    if (!long_run) begin
      if ($urandom_range(99) < 12) begin
        path[$urandom_range(path.size() - 1)] = 8'($urandom_range(255, 1));
      end
      if ($urandom_range(99) < 5) begin
        path.delete();
        repeat ($urandom_range(12, 1)) path.push_back(8'($urandom_range(255, 1)));
      end
    end
    foreach (path[i]) begin
      send_char(path[i]);
    end
    send_char(8'h00);
  endtask

  // Short hand-picked paths: good paths, empty names at the root and deeper,
  // paths without a backslash, bad bytes in name and extension, a second
  // dot, a NUL among the first two bytes, control and high bytes, and a
  // byte that ends the directory scan early.
  task automatic test_directed(input logic on);
    write_wildcards(on);
    send_path("C:\\DIR\\FILE.TXT");
    send_path("C:\\FILE");
    send_path("C:\\");
    send_path("C:\\A\\");
    send_path("AB");
    send_path("C:X");
    send_path("C:\\.X");
    send_path("C:\\A.B.C");
    send_path("C:\\*.?");
    send_path("C:\\A?B\\F*.T?T");
    send_path("");
    send_path("C");
    send_path("C:\\A\001B");
    send_path("C:\\\377\376.\200");
    send_path("C:\\A|B\\C");
    send_path("C:\\A\\\\B");
    send_path("C:\\AB.");
    send_path("C:\\A B\\C.D/");
    wait_for_verdicts();
  endtask

  // A path longer than the counters can hold.
  task automatic test_long_paths();
    write_wildcards(1'b1);
    send_random_path(1'b1);
    wait_for_verdicts();
  endtask

  // Random paths until the byte budget is spent, now and then pausing the
  // input until every verdict has come back.
  task automatic test_random(input logic on, input int n_bytes,
                             input int src_pct, input int snk_pct);
    int stop_at;
    write_wildcards(on);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      send_random_path(1'b0);
      if ($urandom_range(11) == 0) begin
        wait_for_verdicts();
      end
    end
    wait_for_verdicts();
  endtask

  // The receiver stalls in about the requested share of cycles.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every output transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    path_verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (path_verdicts_q.size() == 0) begin
        $display("%0t: unexpected result, got status %0d dir_length %0d", $time,
                 m_tdata[1:0], m_tdata[9:2]);
        errors++;
      end else begin
        want = path_verdicts_q.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status,
                   m_tdata[1:0]);
          errors++;
        end else begin
          status_seen[m_tdata[1:0]]++;
        end
        if (m_tdata[9:2] !== want.dir_len) begin
          $display("%0t: dir_length expected %0d, got %0d", $time, want.dir_len,
                   m_tdata[9:2]);
          errors++;
        end
        if (m_tdata[15:10] !== 6'd0) begin
          $display("%0t: tdata padding expected 0, got %h", $time, m_tdata[15:10]);
          errors++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dos_path_name_validator: mismatch");
      $finish;
    end
  end

  initial begin
    wildcards_on = 1'b0;
    clear_path_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed paths first, without any idling so results follow closely.
    test_directed(1'b0);
    test_directed(1'b1);

    // The long path runs with idling on both sides.
    src_idle_pct = 30;
    snk_idle_pct = 30;
    test_long_paths();

    // Random paths: idling on both sides, a stretch with none at all, a slow
    // receiver that backs the queue up into the input, then idling again.
    test_random(1'b1, RANDOM_BYTES / 3, 30, 30);
    test_random(1'b0, RANDOM_BYTES / 3, 0, 0);
    test_random(1'b1, RANDOM_BYTES / 6, 10, 60);
    test_random(1'b0, RANDOM_BYTES / 6, 30, 30);

    wait_for_verdicts();
    $display("Checked %0d paths (%0d bytes) with wildcards on and off, long paths included.",
             paths_sent, bytes_sent);
    $display("Verdicts: ok %0d, path not found %0d, no more files %0d, file not found %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("dos_path_name_validator: match");
    end else begin
      $display("dos_path_name_validator: mismatch");
    end
    $finish;
  end

endmodule

@@ dos_path_name_validator.f @@
hw/rtl/dpv_pkg.sv
hw/rtl/dpv_front.sv
hw/rtl/dpv_queue.sv
hw/rtl/dpv_back.sv
hw/rtl/dos_path_name_validator.sv
dv/dos_path_name_validator_tb.sv
